### src/ibsc_pkg.sv
// Package for the image buffer size calculator: input codes, size kinds and
// the request that the decode stage hands to the multiplier stage.
// No dependencies.
`timescale 1ns / 1ps

package ibsc_pkg;

  // Pixel format codes.
  localparam logic [3:0] PIX_INVALID = 4'd0;
  localparam logic [3:0] PIX_RGBA8888 = 4'd1;
  localparam logic [3:0] PIX_BGRA32 = 4'd2;
  localparam logic [3:0] PIX_I420 = 4'd3;
  localparam logic [3:0] PIX_M420 = 4'd4;
  localparam logic [3:0] PIX_NV12 = 4'd5;
  localparam logic [3:0] PIX_MJPEG = 4'd7;
  localparam logic [3:0] PIX_YV12 = 4'd8;
  localparam logic [3:0] PIX_L8 = 4'd13;

  // Layout modifier codes.
  localparam logic [2:0] MOD_LINEAR = 3'd0;
  localparam logic [2:0] MOD_X_TILED = 3'd1;
  localparam logic [2:0] MOD_Y_TILED = 3'd2;
  localparam logic [2:0] MOD_YF_TILED = 3'd3;
  localparam logic [2:0] MOD_BLK16X16 = 3'd4;
  localparam logic [2:0] MOD_BLK32X8 = 3'd5;

  localparam int unsigned OP_A_W = 20;
  localparam int unsigned OP_B_W = 16;
  localparam int unsigned PROD_W = OP_A_W + OP_B_W;
  localparam int unsigned SIZE_W = 37;

  // How the product turns into a size.
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_LINEAR,
    KIND_LIN420,
    KIND_TILE,
    KIND_BLOCK
  } size_kind_t;

  typedef struct packed {
    size_kind_t          kind;
    logic [OP_A_W-1:0]   op_a;
    logic [OP_B_W-1:0]   op_b;
  } mul_req_t;

endpackage

### src/ibsc_decode.sv
// Decode of format and layout codes into a multiply request for the image
// buffer size calculator. Depends on ibsc_pkg.
`timescale 1ns / 1ps

module ibsc_decode (
  input  logic [3:0]            pixel_code,
  input  logic                  modifier_present,
  input  logic [2:0]            modifier_code,
  input  logic [15:0]           img_width,
  input  logic [15:0]           img_height,
  input  logic [19:0]           row_bytes,
  output ibsc_pkg::mul_req_t    req
);

  logic        linear_layout;
  logic        linear_fmt;
  logic        planar420;
  logic        rgba32;
  logic [16:0] w_128;
  logic [16:0] w_32;
  logic [16:0] w_16;
  logic [15:0] h_32;
  logic [15:0] h_16;
  logic [15:0] h_8;

  // Ceiling divisions by powers of two: add the divisor less one, then shift.
  assign w_128 = ({1'b0, img_width} + 17'd127) >> 7;
  assign w_32  = ({1'b0, img_width} + 17'd31) >> 5;
  assign w_16  = ({1'b0, img_width} + 17'd15) >> 4;
  assign h_32  = 16'(({1'b0, img_height} + 17'd31) >> 5);
  assign h_16  = 16'(({1'b0, img_height} + 17'd15) >> 4);
  assign h_8   = 16'(({1'b0, img_height} + 17'd7) >> 3);

  assign linear_layout = !modifier_present || (modifier_code == ibsc_pkg::MOD_LINEAR);
  assign linear_fmt = (pixel_code != ibsc_pkg::PIX_INVALID) &&
                      (pixel_code <= ibsc_pkg::PIX_L8) &&
                      (pixel_code != ibsc_pkg::PIX_MJPEG);
  assign planar420 = (pixel_code == ibsc_pkg::PIX_I420) ||
                     (pixel_code == ibsc_pkg::PIX_M420) ||
                     (pixel_code == ibsc_pkg::PIX_NV12) ||
                     (pixel_code == ibsc_pkg::PIX_YV12);
  assign rgba32 = (pixel_code == ibsc_pkg::PIX_RGBA8888) ||
                  (pixel_code == ibsc_pkg::PIX_BGRA32);

  always_comb begin
    req.kind = ibsc_pkg::KIND_NONE;
    req.op_a = '0;
    req.op_b = '0;
    if (linear_layout) begin
      if (linear_fmt) begin
        req.kind = planar420 ? ibsc_pkg::KIND_LIN420 : ibsc_pkg::KIND_LINEAR;
        req.op_a = row_bytes;
        req.op_b = img_height;
      end
    end else if (rgba32) begin
      unique case (modifier_code)
        ibsc_pkg::MOD_X_TILED: begin
          req.kind = ibsc_pkg::KIND_TILE;
          req.op_a = {3'b0, w_128};
          req.op_b = h_8;
        end
        ibsc_pkg::MOD_Y_TILED, ibsc_pkg::MOD_YF_TILED: begin
          req.kind = ibsc_pkg::KIND_TILE;
          req.op_a = {3'b0, w_32};
          req.op_b = h_32;
        end
        ibsc_pkg::MOD_BLK16X16: begin
          req.kind = ibsc_pkg::KIND_BLOCK;
          req.op_a = {3'b0, w_16};
          req.op_b = h_16;
        end
        ibsc_pkg::MOD_BLK32X8: begin
          req.kind = ibsc_pkg::KIND_BLOCK;
          req.op_a = {3'b0, w_32};
          req.op_b = h_8;
        end
        default: begin
          req.kind = ibsc_pkg::KIND_NONE;
        end
      endcase
    end
  end

endmodule

### src/image_buffer_size_calc_unit.sv
// Top level of the image buffer size calculator: input register, multiply
// stage and output register. Depends on ibsc_pkg and ibsc_decode.
// An accepted request passes the input, product and output registers in turn.
// Throughput: one request per cycle while out_tready is high; every stage is
// registered on both sides. Reset (rst_n low, synchronous) empties all three
// stages; payload registers are not cleared.
`timescale 1ns / 1ps

module image_buffer_size_calc_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0 up: pixel_code[3:0], modifier_present[4],
  // modifier_code[7:5], img_width[23:8], img_height[39:24],
  // row_bytes[59:40], zero padding[63:60].
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0 up: supported[0], size_bytes[37:1], zero padding[39:38].
  output logic [39:0] out_tdata
);

  // Stage 1 holds the raw request. Stage 2 holds the product and how it is
  // to be scaled. Stage 3 is the result register.
  logic                        in_v_r, in_v_nxt;
  logic [59:0]                 in_data_r;
  logic                        prod_v_r, prod_v_nxt;
  ibsc_pkg::size_kind_t        prod_kind_r;
  logic [ibsc_pkg::PROD_W-1:0] prod_r;
  logic                        out_v_r, out_v_nxt;
  logic                        out_ok_r;
  logic [ibsc_pkg::SIZE_W-1:0] out_size_r;

  logic                        rdy_a, rdy_b, rdy_out;
  ibsc_pkg::mul_req_t          req;
  logic [ibsc_pkg::PROD_W-1:0] prod_nxt;
  logic [ibsc_pkg::SIZE_W-1:0] size_nxt;
  logic                        ok_nxt;
  logic [ibsc_pkg::PROD_W-1:0] hdr_blocks;

  // Each stage advances when the stage after it is empty or moving, so a
  // result waiting on out_tready does not stop the earlier stages from filling.
  assign rdy_out   = !out_v_r || out_tready;
  assign rdy_b     = !prod_v_r || rdy_out;
  assign rdy_a     = !in_v_r || rdy_b;
  assign in_tready = rdy_a;

  ibsc_decode u_decode (
    .pixel_code       (in_data_r[3:0]),
    .modifier_present (in_data_r[4]),
    .modifier_code    (in_data_r[7:5]),
    .img_width        (in_data_r[23:8]),
    .img_height       (in_data_r[39:24]),
    .row_bytes        (in_data_r[59:40]),
    .req              (req)
  );

  assign prod_nxt = ibsc_pkg::PROD_W'(req.op_a) * ibsc_pkg::PROD_W'(req.op_b);

  // A block layout needs a 16-byte header per block, rounded up to 1024
  // bytes, which is one 1 KiB unit per 64 blocks rounded up.
  assign hdr_blocks = (prod_r + ibsc_pkg::PROD_W'(63)) >> 6;

  always_comb begin
    ok_nxt   = 1'b1;
    size_nxt = '0;
    unique case (prod_kind_r)
      ibsc_pkg::KIND_LINEAR: size_nxt = ibsc_pkg::SIZE_W'(prod_r);
      // Three halves truncated equals the value plus half of it truncated.
      ibsc_pkg::KIND_LIN420: size_nxt = ibsc_pkg::SIZE_W'(prod_r) +
                                        ibsc_pkg::SIZE_W'(prod_r >> 1);
      ibsc_pkg::KIND_TILE:   size_nxt = ibsc_pkg::SIZE_W'(prod_r) << 12;
      // Each block holds 1024 bytes of pixels in either block shape.
      ibsc_pkg::KIND_BLOCK:  size_nxt = (ibsc_pkg::SIZE_W'(prod_r) +
                                         ibsc_pkg::SIZE_W'(hdr_blocks)) << 10;
      default: begin
        ok_nxt   = 1'b0;
        size_nxt = '0;
      end
    endcase
  end

  always_comb begin
    in_v_nxt   = rdy_a ? in_tvalid : in_v_r;
    prod_v_nxt = rdy_b ? in_v_r : prod_v_r;
    out_v_nxt  = rdy_out ? prod_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      in_v_r   <= in_v_nxt;
      prod_v_r <= prod_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && rdy_a) begin
      in_data_r <= in_tdata[59:0];
    end
    if (in_v_r && rdy_b) begin
      prod_kind_r <= req.kind;
      prod_r      <= prod_nxt;
    end
    if (prod_v_r && rdy_out) begin
      out_ok_r   <= ok_nxt;
      out_size_r <= size_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_size_r, out_ok_r};

`ifndef ASSERT_OFF
  a_unsup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[37:1] == '0)
    else $error("unsupported result carries a nonzero size");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> in_v_r)
    else $error("accepted request did not reach the input register");

  a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    prod_v_r && !rdy_out |=> prod_v_r && $stable(prod_r))
    else $error("product stage lost data while stalled");

  a_tile_align: assert property (@(posedge clk) disable iff (!rst_n)
    prod_v_r && rdy_out && prod_kind_r == ibsc_pkg::KIND_TILE
    |=> out_tdata[0] && out_tdata[12:1] == '0)
    else $error("tiled size is not a whole number of tiles");

  a_block_align: assert property (@(posedge clk) disable iff (!rst_n)
    prod_v_r && rdy_out && prod_kind_r == ibsc_pkg::KIND_BLOCK
    |=> out_tdata[0] && out_tdata[10:1] == '0)
    else $error("block layout size is not 1 KiB aligned");
`endif

endmodule

### tb/tb.sv
// Self-checking testbench for image_buffer_size_calc_unit: a directed set and
// a random set of size requests, checked against an in-bench size predictor.
// Depends on ibsc_pkg and the image_buffer_size_calc_unit RTL.
`timescale 1ns / 1ps

module tb;

  // Codes that the checks and the stimulus need beyond those in the package.
  localparam logic [3:0] PIX_BGR24 = 4'd9;
  localparam logic [3:0] PIX_UNDEF_A = 4'd14;
  localparam logic [3:0] PIX_UNDEF_B = 4'd15;
  localparam logic [2:0] MOD_OTHER = 3'd6;
  localparam logic [2:0] MOD_UNUSED = 3'd7;

  localparam logic [63:0] TILE_BYTES = 64'd4096;
  localparam logic [63:0] HDR_BYTES = 64'd16;
  localparam logic [63:0] HDR_ALIGN = 64'd1024;
  localparam logic [63:0] BYTES_PER_PIXEL = 64'd4;

  localparam int unsigned RANDOM_REQUESTS = 1550;
  localparam int unsigned HOLDOFF_AFTER = 150;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned MAX_REPORTS = 10;

  // One request as it travels on in_tdata, pixel_code in the lowest bits.
  typedef struct packed {
    logic [19:0] row_bytes;
    logic [15:0] img_height;
    logic [15:0] img_width;
    logic [2:0]  modifier_code;
    logic        modifier_present;
    logic [3:0]  pixel_code;
  } size_request_t;

  // One result as it travels on out_tdata, supported in bit 0.
  typedef struct packed {
    logic [ibsc_pkg::SIZE_W-1:0] size_bytes;
    logic                        supported;
  } size_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  size_request_t pending_requests[$];
  size_result_t  expected_sizes[$];
  size_request_t offered_request;

  int unsigned error_count = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned holdoff_left = 0;
  bit          holdoff_done = 1'b0;
  logic [7:0]  ready_pattern = 8'hFF;
  logic [5:0]  pattern_step = '0;

  image_buffer_size_calc_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // The clock runs with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] ceil_div(logic [63:0] a, logic [63:0] b);
    return (a + b - 64'd1) / b;
  endfunction

  // Computes the buffer size that the block should return for one request.
  // All arithmetic runs at 64 bits, which is wide enough that nothing wraps.
  function automatic size_result_t predict_buffer_size(size_request_t r);
    logic [63:0]  w;
    logic [63:0]  h;
    logic [63:0]  bw;
    logic [63:0]  bh;
    logic [63:0]  blocks;
    logic [63:0]  size;
    logic         ok;
    size_result_t res;
    w = r.img_width;
    h = r.img_height;
    ok = 1'b0;
    size = '0;
    if (!r.modifier_present || r.modifier_code == ibsc_pkg::MOD_LINEAR) begin
      // A linear layout takes every defined format except the invalid code and
      // MJPEG; the planar 4:2:0 formats add half again for the chroma planes.
      if (r.pixel_code >= ibsc_pkg::PIX_RGBA8888 && r.pixel_code <= ibsc_pkg::PIX_L8 &&
          r.pixel_code != ibsc_pkg::PIX_MJPEG) begin
        ok = 1'b1;
        size = h * 64'(r.row_bytes);
        if (r.pixel_code == ibsc_pkg::PIX_I420 || r.pixel_code == ibsc_pkg::PIX_M420 ||
            r.pixel_code == ibsc_pkg::PIX_NV12 || r.pixel_code == ibsc_pkg::PIX_YV12) begin
          size = size * 64'd3 / 64'd2;
        end
      end
    end else if (r.pixel_code == ibsc_pkg::PIX_RGBA8888 ||
                 r.pixel_code == ibsc_pkg::PIX_BGRA32) begin
      case (r.modifier_code)
        ibsc_pkg::MOD_X_TILED: begin
          ok = 1'b1;
          size = ceil_div(w, 64'd128) * ceil_div(h, 64'd8) * TILE_BYTES;
        end
        ibsc_pkg::MOD_Y_TILED, ibsc_pkg::MOD_YF_TILED: begin
          ok = 1'b1;
          size = ceil_div(w, 64'd32) * ceil_div(h, 64'd32) * TILE_BYTES;
        end
        ibsc_pkg::MOD_BLK16X16, ibsc_pkg::MOD_BLK32X8: begin
          bw = (r.modifier_code == ibsc_pkg::MOD_BLK16X16) ? 64'd16 : 64'd32;
          bh = (r.modifier_code == ibsc_pkg::MOD_BLK16X16) ? 64'd16 : 64'd8;
          blocks = ceil_div(w, bw) * ceil_div(h, bh);
          ok = 1'b1;
          size = blocks * bw * bh * BYTES_PER_PIXEL +
                 ceil_div(blocks * HDR_BYTES, HDR_ALIGN) * HDR_ALIGN;
        end
        default: ;
      endcase
    end
    res.supported = ok;
    res.size_bytes = ok ? size[ibsc_pkg::SIZE_W-1:0] : '0;
    return res;
  endfunction

  function automatic size_request_t make_request(logic [3:0] pix, logic present,
                                                 logic [2:0] modc, logic [15:0] w,
                                                 logic [15:0] h, logic [19:0] rb);
    size_request_t r;
    r.pixel_code = pix;
    r.modifier_present = present;
    r.modifier_code = modc;
    r.img_width = w;
    r.img_height = h;
    r.row_bytes = rb;
    return r;
  endfunction

  // Picks a dimension or row byte count up to max: zero, the maximum, small
  // values, values next to a multiple of 32 (tile edges) or anything at all.
  function automatic int unsigned random_extent(int unsigned max);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return max;
      2, 3: return $urandom_range(1, 300);
      4: return ($urandom_range(1, max / 32) * 32 + $urandom_range(0, 2) - 1) & max;
      default: return $urandom() & max;
    endcase
  endfunction

  // Sender: each request is offered until the block takes it, and the next one
  // follows at once within a burst. Bursts of random length alternate with
  // random gaps, some of them zero so that long stretches run back to back.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_sizes.push_back(predict_buffer_size(offered_request));
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          offered_request = pending_requests.pop_front();
          in_tdata <= {4'b0, offered_request};
          in_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: every accepted result is checked against the oldest prediction.
  // Readiness follows an 8-step pattern that is redrawn whenever the 6-bit step
  // counter wraps, and once, after a number of results, the receiver holds off
  // long enough for the pipeline to fill and back up onto the sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_sizes.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: result with no request waiting: out_tdata=%h", $realtime,
                     out_tdata);
          end
        end else begin
          size_result_t want;
          size_result_t got;
          want = expected_sizes.pop_front();
          got = out_tdata[ibsc_pkg::SIZE_W:0];
          if (got.supported !== want.supported || got.size_bytes !== want.size_bytes) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("%0t: mismatch: supported exp %0d got %0d, size_bytes exp %0d got %0d",
                       $realtime, want.supported, got.supported, want.size_bytes,
                       got.size_bytes);
            end
          end
        end
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_tready <= 1'b0;
      end else if (!holdoff_done && results_seen >= HOLDOFF_AFTER) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
        out_tready <= 1'b0;
      end else begin
        if (pattern_step == 0) begin
          case ($urandom_range(0, 3))
            0: ready_pattern = 8'hFF;
            1: ready_pattern = 8'hAA;
            default: ready_pattern = 8'($urandom()) | 8'h01;
          endcase
        end
        out_tready <= ready_pattern[pattern_step[2:0]];
        pattern_step++;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    size_request_t r;
    // Directed requests: field extremes, every layout, and the special cases.
    // Linear layouts, including the largest linear and planar products.
    pending_requests.push_back(make_request(ibsc_pkg::PIX_RGBA8888, 1'b0,
                                            ibsc_pkg::MOD_LINEAR, 16'd0, 16'd0, 20'd0));
    pending_requests.push_back(make_request(ibsc_pkg::PIX_L8, 1'b0, ibsc_pkg::MOD_LINEAR,
                                            16'hFFFF, 16'hFFFF, 20'hFFFFF));
    pending_requests.push_back(make_request(ibsc_pkg::PIX_I420, 1'b0, ibsc_pkg::MOD_LINEAR,
                                            16'hFFFF, 16'hFFFF, 20'hFFFFF));
    // Planar formats with an odd product, where the halving truncates, and one non-planar format.
    pending_requests.push_back(make_request(ibsc_pkg::PIX_NV12, 1'b0, ibsc_pkg::MOD_LINEAR,
                                            16'd7, 16'd3, 20'd5));
    pending_requests.push_back(make_request(ibsc_pkg::PIX_M420, 1'b1, ibsc_pkg::MOD_LINEAR,
                                            16'd1, 16'd1, 20'd1));
    pending_requests.push_back(make_request(ibsc_pkg::PIX_YV12, 1'b0, ibsc_pkg::MOD_LINEAR,
                                            16'd640, 16'd481, 20'd641));
    pending_requests.push_back(make_request(PIX_BGR24, 1'b0, ibsc_pkg::MOD_LINEAR,
                                            16'd100, 16'd9, 20'd300));
    // Unsupported linear formats: invalid, MJPEG and the two undefined codes.
    pending_requests.push_back(make_request(ibsc_pkg::PIX_INVALID, 1'b0,
                                            ibsc_pkg::MOD_LINEAR, 16'd8, 16'd8, 20'd32));
    pending_requests.push_back(make_request(ibsc_pkg::PIX_MJPEG, 1'b0,
                                            ibsc_pkg::MOD_LINEAR, 16'd8, 16'd8, 20'd32));
    pending_requests.push_back(make_request(PIX_UNDEF_A, 1'b0, ibsc_pkg::MOD_LINEAR,
                                            16'd8, 16'd8, 20'd32));
    pending_requests.push_back(make_request(PIX_UNDEF_B, 1'b1, ibsc_pkg::MOD_LINEAR,
                                            16'd8, 16'd8, 20'd32));
    // The modifier code means nothing while modifier_present is low.
    pending_requests.push_back(make_request(ibsc_pkg::PIX_RGBA8888, 1'b0,
                                            ibsc_pkg::MOD_X_TILED, 16'd129, 16'd9,
                                            20'd1000));
    pending_requests.push_back(make_request(PIX_BGR24, 1'b0, MOD_UNUSED, 16'd5, 16'd5,
                                            20'd15));
    // Tiled layouts at the edges of a tile and at the largest size.
    pending_requests.push_back(make_request(ibsc_pkg::PIX_RGBA8888, 1'b1,
                                            ibsc_pkg::MOD_X_TILED, 16'd129, 16'd9, 20'd0));
    pending_requests.push_back(make_request(ibsc_pkg::PIX_BGRA32, 1'b1,
                                            ibsc_pkg::MOD_X_TILED, 16'hFFFF, 16'hFFFF,
                                            20'hFFFFF));
    pending_requests.push_back(make_request(ibsc_pkg::PIX_BGRA32, 1'b1,
                                            ibsc_pkg::MOD_Y_TILED, 16'd32, 16'd33, 20'd0));
    pending_requests.push_back(make_request(ibsc_pkg::PIX_RGBA8888, 1'b1,
                                            ibsc_pkg::MOD_YF_TILED, 16'hFFFF, 16'hFFFF,
                                            20'd0));
    // Block layouts: a zero width gives a supported size of zero.
    pending_requests.push_back(make_request(ibsc_pkg::PIX_RGBA8888, 1'b1,
                                            ibsc_pkg::MOD_BLK16X16, 16'd0, 16'd5, 20'd0));
    pending_requests.push_back(make_request(ibsc_pkg::PIX_BGRA32, 1'b1,
                                            ibsc_pkg::MOD_BLK16X16, 16'd17, 16'd17,
                                            20'd0));
    pending_requests.push_back(make_request(ibsc_pkg::PIX_RGBA8888, 1'b1,
                                            ibsc_pkg::MOD_BLK32X8, 16'hFFFF, 16'hFFFF,
                                            20'hFFFFF));
    pending_requests.push_back(make_request(ibsc_pkg::PIX_BGRA32, 1'b1,
                                            ibsc_pkg::MOD_BLK32X8, 16'd33, 16'd0, 20'd0));
    // Unsupported modifiers, and a tiled layout with a format it does not take.
    pending_requests.push_back(make_request(ibsc_pkg::PIX_RGBA8888, 1'b1, MOD_OTHER,
                                            16'd64, 16'd64, 20'd256));
    pending_requests.push_back(make_request(ibsc_pkg::PIX_BGRA32, 1'b1, MOD_UNUSED,
                                            16'd64, 16'd64, 20'd256));
    pending_requests.push_back(make_request(ibsc_pkg::PIX_NV12, 1'b1,
                                            ibsc_pkg::MOD_Y_TILED, 16'd64, 16'd64,
                                            20'd256));

    // Random requests. Most target a supported layout so that the size paths
    // get exercised; the rest are drawn from the whole field space.
    for (int unsigned i = 0; i < RANDOM_REQUESTS; i++) begin
      r.pixel_code = 4'($urandom_range(0, 15));
      r.modifier_present = 1'($urandom_range(0, 1));
      r.modifier_code = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if (r.modifier_present) r.modifier_code = ibsc_pkg::MOD_LINEAR;
        end
        4, 5, 6, 7: begin
          r.modifier_present = 1'b1;
          r.modifier_code = 3'($urandom_range(ibsc_pkg::MOD_X_TILED,
                                              ibsc_pkg::MOD_BLK32X8));
          if ($urandom_range(0, 3) != 0) begin
            r.pixel_code = $urandom_range(0, 1) ? ibsc_pkg::PIX_RGBA8888 :
                                                  ibsc_pkg::PIX_BGRA32;
          end
        end
        default: ;
      endcase
      r.img_width = 16'(random_extent(16'hFFFF));
      r.img_height = 16'(random_extent(16'hFFFF));
      r.row_bytes = 20'(random_extent(20'hFFFFF));
      pending_requests.push_back(r);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every request has been taken and every result has come back,
    // then let any stray result show before the run ends.
    while (pending_requests.size() > 0 || in_tvalid || expected_sizes.size() > 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
